>>> rtl/core/phx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phx_pkg
// Shared types, constants and the round mixing function of the Philox4x32
// generator.
// ----------------------------------------------------------------------------
package phx_pkg;

  localparam int unsigned WordW         = 32;
  localparam int unsigned RoundCountDef = 10;
  localparam int unsigned CfgIdxW       = 1;

  localparam logic [WordW-1:0] MulA  = 32'hD2511F53;
  localparam logic [WordW-1:0] MulB  = 32'hCD9E8D57;
  localparam logic [WordW-1:0] WeylA = 32'h9E3779B9;
  localparam logic [WordW-1:0] WeylB = 32'hBB67AE85;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyLow  = 1'b0,
    CfgKeyHigh = 1'b1
  } phx_cfg_idx_e;

  typedef logic [3:0][WordW-1:0] phx_words_t;

  // Products of one round plus the pass-through odd words.
  typedef struct packed {
    logic [2*WordW-1:0] prod_a;
    logic [2*WordW-1:0] prod_b;
    logic [WordW-1:0]   word_1;
    logic [WordW-1:0]   word_3;
  } phx_stage_t;

  function automatic phx_words_t phx_mix(input phx_stage_t st,
                                         input logic [WordW-1:0] k0,
                                         input logic [WordW-1:0] k1);
    phx_words_t w;
    w[0] = st.prod_b[2*WordW-1:WordW] ^ st.word_1 ^ k0;
    w[1] = st.prod_b[WordW-1:0];
    w[2] = st.prod_a[2*WordW-1:WordW] ^ st.word_3 ^ k1;
    w[3] = st.prod_a[WordW-1:0];
    return w;
  endfunction

endpackage

>>> rtl/core/phx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phx_if
// Valid/ready channels for counter transactions and random word transactions.
// ----------------------------------------------------------------------------
interface phx_ctr_if;
  logic        valid;
  logic        ready;
  logic [31:0] counter_word_0;
  logic [31:0] counter_word_1;
  logic [31:0] counter_word_2;
  logic [31:0] counter_word_3;

  modport source (output valid, counter_word_0, counter_word_1, counter_word_2,
                  counter_word_3, input ready);
  modport sink   (input valid, counter_word_0, counter_word_1, counter_word_2,
                  counter_word_3, output ready);
endinterface

interface phx_rnd_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word_0;
  logic [31:0] random_word_1;
  logic [31:0] random_word_2;
  logic [31:0] random_word_3;

  modport source (output valid, random_word_0, random_word_1, random_word_2,
                  random_word_3, input ready);
  modport sink   (input valid, random_word_0, random_word_1, random_word_2,
                  random_word_3, output ready);
endinterface

>>> rtl/core/philox4x32_10_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// philox4x32_10_generator
// Pipelined Philox4x32 generator: one multiply stage per round plus an
// output register.
//
//   Channel   Dir  Handshake      Payload
//   ctr_i     in   valid/ready    counter_word_0..3   (32 b each)
//   rnd_o     out  valid/ready    random_word_0..3    (32 b each)
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i (key words)
//
// Accepts one counter per cycle unless back-pressure stalls it; each counter
// passes one registered multiply stage per round and the output register.
// Reset clears all valid bits and the key words to zero.
// Back-pressure stalls each stage only when it holds data that cannot move;
// bubbles are squeezed out.
// ----------------------------------------------------------------------------
module philox4x32_10_generator import phx_pkg::*; #(
  parameter int unsigned ROUND_COUNT = RoundCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  phx_ctr_if.sink            ctr_i,
  phx_rnd_if.source          rnd_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_wdata_i
);

  logic [WordW-1:0] rk0 [ROUND_COUNT];
  logic [WordW-1:0] rk1 [ROUND_COUNT];

  phx_key_sched #(.ROUND_COUNT(ROUND_COUNT)) u_key_sched (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .rk0_o (rk0),
    .rk1_o (rk1)
  );

  logic       st_valid [ROUND_COUNT+1];
  logic       st_ready [ROUND_COUNT+1];
  phx_words_t st_words [ROUND_COUNT+1];
  phx_stage_t st_data  [ROUND_COUNT];

  assign st_valid[0]    = ctr_i.valid;
  assign ctr_i.ready    = st_ready[0];
  assign st_words[0][0] = ctr_i.counter_word_0;
  assign st_words[0][1] = ctr_i.counter_word_1;
  assign st_words[0][2] = ctr_i.counter_word_2;
  assign st_words[0][3] = ctr_i.counter_word_3;

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    logic valid_r;

    phx_round u_round (
      .clk_i,
      .rst_ni,
      .valid_i (st_valid[r]),
      .ready_o (st_ready[r]),
      .words_i (st_words[r]),
      .valid_o (valid_r),
      .ready_i (st_ready[r+1]),
      .stage_o (st_data[r])
    );

    assign st_valid[r+1] = valid_r;
    assign st_words[r+1] = phx_mix(st_data[r], rk0[r], rk1[r]);
  end

  // Output register
  logic       out_valid_q;
  phx_words_t out_words_q;

  assign st_ready[ROUND_COUNT] = !out_valid_q || rnd_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_ready[ROUND_COUNT]) begin
      out_valid_q <= st_valid[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_ready[ROUND_COUNT] && st_valid[ROUND_COUNT]) begin
      out_words_q <= st_words[ROUND_COUNT];
    end
  end

  assign rnd_o.valid         = out_valid_q;
  assign rnd_o.random_word_0 = out_words_q[0];
  assign rnd_o.random_word_1 = out_words_q[1];
  assign rnd_o.random_word_2 = out_words_q[2];
  assign rnd_o.random_word_3 = out_words_q[3];

endmodule

>>> rtl/core/phx_key_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phx_key_sched
// Key registers and the per-round key schedule (Weyl increments).
// ----------------------------------------------------------------------------
module phx_key_sched import phx_pkg::*; #(
  parameter int unsigned ROUND_COUNT = RoundCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WordW-1:0]    cfg_wdata_i,
  output logic [WordW-1:0]    rk0_o [ROUND_COUNT],
  output logic [WordW-1:0]    rk1_o [ROUND_COUNT]
);

  logic [WordW-1:0] key_lo_q, key_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (phx_cfg_idx_e'(cfg_idx_i))
        CfgKeyLow:  key_lo_q <= cfg_wdata_i;
        CfgKeyHigh: key_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rk0_o[0] = key_lo_q;
  assign rk1_o[0] = key_hi_q;

  // Round r's keys are used only past round r's register, so registering them is safe.
  for (genvar r = 1; r < ROUND_COUNT; r++) begin : g_rk
    localparam logic [2*WordW-1:0] OffA = (2*WordW)'(r) * {{WordW{1'b0}}, WeylA};
    localparam logic [2*WordW-1:0] OffB = (2*WordW)'(r) * {{WordW{1'b0}}, WeylB};
    logic [WordW-1:0] rk0_q, rk1_q;

    always_ff @(posedge clk_i) begin
      rk0_q <= key_lo_q + OffA[WordW-1:0];
      rk1_q <= key_hi_q + OffB[WordW-1:0];
    end

    assign rk0_o[r] = rk0_q;
    assign rk1_o[r] = rk1_q;
  end

endmodule

>>> rtl/core/phx_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phx_round
// One pipeline stage: both round multiplications, registered, with
// valid/ready flow control.
// ----------------------------------------------------------------------------
module phx_round import phx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  phx_words_t words_i,
  output logic       valid_o,
  input  logic       ready_i,
  output phx_stage_t stage_o
);

  logic       valid_q;
  phx_stage_t stage_q, stage_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    stage_d.prod_a = {{WordW{1'b0}}, words_i[0]} * {{WordW{1'b0}}, MulA};
    stage_d.prod_b = {{WordW{1'b0}}, words_i[2]} * {{WordW{1'b0}}, MulB};
    stage_d.word_1 = words_i[1];
    stage_d.word_3 = words_i[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

>>> dv/philox4x32_10_generator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// philox4x32_10_generator_checker
// Watches the counter, random word and key ports of the Philox4x32 generator.
// Each accepted counter transaction is run through an independent model of
// the rounds under the current key. The resulting words are queued and
// compared word by word with each random word transaction, in order.
// ----------------------------------------------------------------------------
module philox4x32_10_generator_checker import phx_pkg::*; #(
  parameter int unsigned ROUND_COUNT = RoundCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  phx_ctr_if                 ctr_i,
  phx_rnd_if                 rnd_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_wdata_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);

  logic [WordW-1:0] key_lo;
  logic [WordW-1:0] key_hi;
  phx_words_t       words_due_q[$];
  phx_words_t       want;
  phx_words_t       got;

  function automatic phx_words_t philox_block(input phx_words_t       ctr,
                                              input logic [WordW-1:0] k_lo,
                                              input logic [WordW-1:0] k_hi);
    phx_words_t         w;
    logic [2*WordW-1:0] prod_a;
    logic [2*WordW-1:0] prod_b;
    logic [WordW-1:0]   k0;
    logic [WordW-1:0]   k1;
    w  = ctr;
    k0 = k_lo;
    k1 = k_hi;
    for (int r = 0; r < ROUND_COUNT; r++) begin
      if (r > 0) begin
        k0 = k0 + WeylA;
        k1 = k1 + WeylB;
      end
      prod_a = 64'(MulA) * 64'(w[0]);
      prod_b = 64'(MulB) * 64'(w[2]);
      w = {prod_a[WordW-1:0], prod_a[2*WordW-1:WordW] ^ w[3] ^ k1,
           prod_b[WordW-1:0], prod_b[2*WordW-1:WordW] ^ w[1] ^ k0};
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo = '0;
      key_hi = '0;
      words_due_q.delete();
    end else begin
      if (ctr_i.valid && ctr_i.ready) begin
        words_due_q.push_back(philox_block({ctr_i.counter_word_3, ctr_i.counter_word_2,
                                            ctr_i.counter_word_1, ctr_i.counter_word_0},
                                           key_lo, key_hi));
      end
      if (rnd_i.valid && rnd_i.ready) begin
        got = {rnd_i.random_word_3, rnd_i.random_word_2,
               rnd_i.random_word_1, rnd_i.random_word_0};
        if (words_due_q.size() == 0) begin
          $error("random word transaction with no counter pending: %032h", got);
          fail_count_o++;
        end else begin
          want = words_due_q.pop_front();
          checked_o++;
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              $error("random_word_%0d mismatch: expected %08h, actual %08h",
                     i, want[i], got[i]);
              fail_count_o++;
            end
          end
        end
      end
      // key takes effect for counters accepted after this edge
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgKeyLow: begin
            key_lo = cfg_wdata_i;
          end
          CfgKeyHigh: begin
            key_hi = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
    end
    pending_o = words_due_q.size();
  end

endmodule

>>> dv/philox4x32_10_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// philox4x32_10_generator_test
// Regression for the Philox4x32-10 generator. Directed counters under the
// reset key, then random counter streams (random, sequential, sparse and
// single-bit-flip) under a series of keys including the extremes. Keys change
// only after the pipeline has drained. Both channels idle in random bursts,
// except in the final phase. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module philox4x32_10_generator_test;
  import phx_pkg::*;

  localparam int unsigned RoundCount  = RoundCountDef;
  localparam int unsigned ItemsPerKey = 65;
  localparam int unsigned KeyCount    = 7;
  localparam int unsigned CycleLimit  = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [WordW-1:0]   cfg_wdata;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        checked;
  int unsigned        cycle_count;
  bit                 quiet_phase;
  phx_words_t         seq_counter;
  phx_words_t         last_counter;

  phx_ctr_if ctr_ch ();
  phx_rnd_if rnd_ch ();

  philox4x32_10_generator #(
    .ROUND_COUNT (RoundCount)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctr_i       (ctr_ch),
    .rnd_o       (rnd_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  philox4x32_10_generator_checker #(
    .ROUND_COUNT (RoundCount)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctr_i        (ctr_ch),
    .rnd_i        (rnd_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("philox4x32_10_generator regression: fail");
        $finish;
      end
    end
  end

  // sink side: ready holds a randomly chosen level for random bursts
  initial begin
    int unsigned burst;
    bit          level;
    rnd_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      burst = $urandom_range(1, 16);
      level = quiet_phase || ($urandom_range(0, 3) != 0);
      @(negedge clk_i);
      rnd_ch.ready <= level;
      repeat (burst - 1) @(negedge clk_i);
    end
  end

  task automatic send_counter(input phx_words_t words);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      ctr_ch.valid          <= 1'b0;
      ctr_ch.counter_word_0 <= $urandom();
      ctr_ch.counter_word_1 <= $urandom();
      ctr_ch.counter_word_2 <= $urandom();
      ctr_ch.counter_word_3 <= $urandom();
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    ctr_ch.valid          <= 1'b1;
    ctr_ch.counter_word_0 <= words[0];
    ctr_ch.counter_word_1 <= words[1];
    ctr_ch.counter_word_2 <= words[2];
    ctr_ch.counter_word_3 <= words[3];
    do @(posedge clk_i); while (!ctr_ch.ready);
    last_counter = words;
  endtask

  // stop the sender and let every outstanding transaction come back
  task automatic drain_pipeline();
    @(negedge clk_i);
    ctr_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic load_key(input logic [WordW-1:0] lo, input logic [WordW-1:0] hi);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgKeyLow;
    cfg_wdata <= lo;
    @(negedge clk_i);
    cfg_idx   <= CfgKeyHigh;
    cfg_wdata <= hi;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [WordW-1:0] sparse_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, WordW - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic phx_words_t pick_counter();
    phx_words_t w;
    case ($urandom_range(0, 3))
      0: begin
        w = {$urandom(), $urandom(), $urandom(), $urandom()};
      end
      1: begin
        // sequential counters, occasionally restarted near a carry boundary
        if ($urandom_range(0, 15) == 0) begin
          seq_counter = {$urandom(), $urandom(), sparse_word(),
                         32'hFFFF_FFFF - $urandom_range(0, 3)};
        end
        seq_counter = seq_counter + 128'd1;
        w = seq_counter;
      end
      2: begin
        w = {sparse_word(), sparse_word(), sparse_word(), sparse_word()};
      end
      default: begin
        w = last_counter;
        w[2'($urandom_range(0, 3))][5'($urandom_range(0, WordW - 1))] ^= 1'b1;
      end
    endcase
    return w;
  endfunction

  initial begin
    phx_words_t       w;
    logic [WordW-1:0] key_lo_list [KeyCount];
    logic [WordW-1:0] key_hi_list [KeyCount];

    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CfgKeyLow;
    cfg_wdata             = '0;
    ctr_ch.valid          = 1'b0;
    ctr_ch.counter_word_0 = '0;
    ctr_ch.counter_word_1 = '0;
    ctr_ch.counter_word_2 = '0;
    ctr_ch.counter_word_3 = '0;
    quiet_phase           = 1'b0;
    seq_counter           = {$urandom(), $urandom(), $urandom(), $urandom()};
    last_counter          = '0;

    key_lo_list = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hA409_3822,
                    $urandom(), $urandom(), 32'h0000_0000};
    key_hi_list = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h299F_31D0,
                    $urandom(), $urandom(), 32'h0000_0000};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed counters under the reset key
    send_counter('0);
    send_counter('1);
    send_counter({4{32'hAAAA_AAAA}});
    send_counter({4{32'h5555_5555}});
    send_counter({32'h0370_7344, 32'h1319_8A2E, 32'h85A3_08D3, 32'h243F_6A88});
    for (int i = 0; i < 4; i++) begin
      w    = '0;
      w[i] = '1;
      send_counter(w);
      w[i] = 32'h0000_0001;
      send_counter(w);
      w[i] = 32'h8000_0000;
      send_counter(w);
    end
    drain_pipeline();

    for (int k = 0; k < KeyCount; k++) begin
      load_key(key_lo_list[k], key_hi_list[k]);
      quiet_phase = (k == KeyCount - 1);
      if (k == 0) begin
        send_counter('0);
        send_counter('1);
      end
      for (int n = 0; n < ItemsPerKey; n++) begin
        send_counter(pick_counter());
      end
      drain_pipeline();
    end

    repeat (RoundCount + 4) @(negedge clk_i);
    $display("checked %0d random word transactions under %0d key settings",
             checked, KeyCount + 1);
    $display("covered extreme, sequential, sparse and bit-flip counters with idle on both sides");
    if (fail_count == 0 && pending == 0) begin
      $display("philox4x32_10_generator regression: pass");
    end else begin
      $display("philox4x32_10_generator regression: fail");
    end
    $finish;
  end

endmodule
